// File: src/pll_divider_search_core_assert.svh
// Assertion macros shared by the divider search block
`ifndef PLL_DIVIDER_SEARCH_CORE_ASSERT_SVH
`define PLL_DIVIDER_SEARCH_CORE_ASSERT_SVH

// Same-cycle implication, clocked on clk, quiet while rst is high
`define PDS_ASSERT_SAME(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// Next-cycle implication, clocked on clk, quiet while rst is high
`define PDS_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

// File: src/pds_pkg.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// pds_pkg
// Types, constants and command/status bundles of the PLL divider search.
// ---------------------------------------------------------------------------
package pds_pkg;

  localparam int MAX_PRE_DIV = 10;
  localparam int MAX_DIV     = 512;
  localparam int FRAC_BITS   = 16;

  localparam int REF_W    = 28;
  localparam int VCO_HZ_W = 32;
  localparam int PFD_HZ_W = 28;
  localparam int TGT_W    = 31;
  localparam int M_W      = 10;
  localparam int N_W      = 4;
  localparam int C_W      = 10;
  localparam int ACH_HZ_W = 32;
  localparam int CFG_W    = 32;
  localparam int IDX_W    = 2;

  localparam int PFD_W  = REF_W + FRAC_BITS;      // 44
  localparam int VQ_W   = VCO_HZ_W + FRAC_BITS;   // 48
  localparam int TQ_W   = TGT_W + FRAC_BITS;      // 47
  localparam int PROD_W = PFD_W + M_W;            // 54
  localparam int DVD_W  = VQ_W + 1;               // 49
  localparam int DVS_W  = VQ_W;                   // 48
  localparam int CNT_W  = $clog2(DVD_W + 1);

  // register indexes
  localparam logic [IDX_W-1:0] REG_REF_CLOCK = 2'd0;
  localparam logic [IDX_W-1:0] REG_VCO_MIN   = 2'd1;
  localparam logic [IDX_W-1:0] REG_VCO_MAX   = 2'd2;
  localparam logic [IDX_W-1:0] REG_PFD_MIN   = 2'd3;

  typedef enum logic [2:0] {
    DIV_PFD,
    DIV_MLO,
    DIV_MHI,
    DIV_C0,
    DIV_ACH
  } pds_div_sel_t;

  typedef struct packed {
    logic         load;
    logic         div_go;
    pds_div_sel_t div_sel;
    logic         next_n;
    logic         calc_vco;
    logic         next_m;
    logic         next_c;
  } pds_cmd_t;

  typedef struct packed {
    logic tgt_zero;
    logic n_over;
    logic pfd_skip;
    logic m_over;
    logic vco_out;
    logic c_over;
    logic div_busy;
    logic div_done;
  } pds_stat_t;

endpackage

// File: src/pds_div.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// pds_div
// Restoring radix-2 divider, one quotient bit per cycle.
// ---------------------------------------------------------------------------
module pds_div (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      go,
  input  logic [pds_pkg::DVD_W-1:0] dividend,
  input  logic [pds_pkg::DVS_W-1:0] divisor,
  output logic                      busy,
  output logic                      done,
  output logic [pds_pkg::DVD_W-1:0] quotient
);
  import pds_pkg::*;

  logic [DVS_W-1:0] rem;
  logic [DVS_W-1:0] dvs;
  logic [DVD_W-1:0] quo;
  logic [CNT_W-1:0] cnt;
  logic [DVS_W:0]   shifted;
  logic [DVS_W:0]   diff;

  // trial subtract of the shifted partial remainder
  assign shifted  = {rem, quo[DVD_W-1]};
  assign diff     = shifted - {1'b0, dvs};
  assign quotient = quo;

  // control: run DVD_W steps, pulse done after the last
  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (go && !busy) begin
        busy <= 1'b1;
        cnt  <= CNT_W'(DVD_W);
      end else if (busy) begin
        cnt <= cnt - 1'b1;
        if (cnt == CNT_W'(1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  // datapath: partial remainder and quotient shift register
  always_ff @(posedge clk) begin
    if (go && !busy) begin
      rem <= '0;
      dvs <= divisor;
      quo <= dividend;
    end else if (busy) begin
      if (!diff[DVS_W]) begin
        rem <= diff[DVS_W-1:0];
        quo <= {quo[DVD_W-2:0], 1'b1};
      end else begin
        rem <= shifted[DVS_W-1:0];
        quo <= {quo[DVD_W-2:0], 1'b0};
      end
    end
  end

endmodule

// File: src/pds_datapath.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// pds_datapath
// Configuration registers, search counters, shared divider and best result.
// ---------------------------------------------------------------------------
module pds_datapath (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         cfg_we,
  input  logic [pds_pkg::IDX_W-1:0]    cfg_index,
  input  logic [pds_pkg::CFG_W-1:0]    cfg_data,
  input  logic [pds_pkg::TGT_W-1:0]    target_freq,
  input  pds_pkg::pds_cmd_t            cmd,
  output pds_pkg::pds_stat_t           st,
  output logic [pds_pkg::M_W-1:0]      mult_m,
  output logic [pds_pkg::N_W-1:0]      pre_div_n,
  output logic [pds_pkg::C_W-1:0]      post_div_c,
  output logic [pds_pkg::ACH_HZ_W-1:0] achieved_hz,
  output logic                         found
);
  import pds_pkg::*;

  logic [REF_W-1:0]    ref_clock;
  logic [VCO_HZ_W-1:0] vco_min;
  logic [VCO_HZ_W-1:0] vco_max;
  logic [PFD_HZ_W-1:0] pfd_min;

  logic [TGT_W-1:0]  target;
  logic [N_W-1:0]    n;
  logic [M_W-1:0]    m;
  logic [M_W-1:0]    m_lo;
  logic [M_W-1:0]    m_hi;
  logic [C_W-1:0]    c;
  logic [C_W-1:0]    c_hi;
  logic [PFD_W-1:0]  pfd;
  logic [PROD_W-1:0] vco;
  logic [VQ_W-1:0]   ach;
  pds_div_sel_t      sel;

  logic [M_W-1:0]  best_m;
  logic [N_W-1:0]  best_n;
  logic [C_W-1:0]  best_c;
  logic [VQ_W-1:0] win_ach;
  logic [VQ_W-1:0] win_err;

  logic [VQ_W-1:0]  tgt_q;
  logic [VQ_W-1:0]  vmin_q;
  logic [VQ_W-1:0]  vmax_q;
  logic [PFD_W-1:0] floor_q;
  logic [VQ_W-1:0]  err;
  logic [VQ_W:0]    ach_round;

  logic [DVD_W-1:0] dvd;
  logic [DVS_W-1:0] dvs;
  logic [DVD_W-1:0] quo;
  logic             div_busy;
  logic             div_done;

  logic [M_W-1:0] q_m_lo;
  logic [C_W-1:0] q_c0;

  assign tgt_q   = {1'b0, target, {FRAC_BITS{1'b0}}};
  assign vmin_q  = {vco_min, {FRAC_BITS{1'b0}}};
  assign vmax_q  = {vco_max, {FRAC_BITS{1'b0}}};
  assign floor_q = {pfd_min, {FRAC_BITS{1'b0}}};

  // configuration writes
  always_ff @(posedge clk) begin
    if (rst) begin
      ref_clock <= REF_W'(50000000);
      vco_min   <= VCO_HZ_W'(600000000);
      vco_max   <= VCO_HZ_W'(1300000000);
      pfd_min   <= PFD_HZ_W'(5000000);
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_REF_CLOCK: ref_clock <= cfg_data[REF_W-1:0];
        REG_VCO_MIN:   vco_min   <= cfg_data[VCO_HZ_W-1:0];
        REG_VCO_MAX:   vco_max   <= cfg_data[VCO_HZ_W-1:0];
        REG_PFD_MIN:   pfd_min   <= cfg_data[PFD_HZ_W-1:0];
        default: ;
      endcase
    end
  end

  // select divider operands for the requested quotient
  always_comb begin
    dvd = '0;
    dvs = '0;
    unique case (cmd.div_sel)
      DIV_PFD: begin
        dvd = DVD_W'({ref_clock, {FRAC_BITS{1'b0}}});
        dvs = DVS_W'(n);
      end
      DIV_MLO: begin
        dvd = DVD_W'(vmin_q);
        dvs = DVS_W'(pfd);
      end
      DIV_MHI: begin
        dvd = DVD_W'(vmax_q);
        dvs = DVS_W'(pfd);
      end
      DIV_C0: begin
        dvd = DVD_W'(vco[VQ_W-1:0]) + DVD_W'({target, {(FRAC_BITS-1){1'b0}}});
        dvs = tgt_q;
      end
      DIV_ACH: begin
        dvd = DVD_W'(vco[VQ_W-1:0]);
        dvs = DVS_W'(c);
      end
      default: ;
    endcase
  end

  pds_div u_div (
    .clk      (clk),
    .rst      (rst),
    .go       (cmd.div_go),
    .dividend (dvd),
    .divisor  (dvs),
    .busy     (div_busy),
    .done     (div_done),
    .quotient (quo)
  );

  // saturate wide quotients into the counter ranges
  always_comb begin
    if (quo > DVD_W'({M_W{1'b1}})) q_m_lo = {M_W{1'b1}};
    else q_m_lo = quo[M_W-1:0];
    if (q_m_lo == '0) q_m_lo = M_W'(1);
    if (quo > DVD_W'({C_W{1'b1}})) q_c0 = {C_W{1'b1}};
    else q_c0 = quo[C_W-1:0];
  end

  assign err = (ach >= tgt_q) ? (ach - tgt_q) : (tgt_q - ach);

  // search registers
  always_ff @(posedge clk) begin
    if (rst) begin
      found <= 1'b0;
      sel   <= DIV_PFD;
    end else begin
      if (cmd.div_go) sel <= cmd.div_sel;
      if (cmd.load) begin
        target  <= target_freq;
        n       <= N_W'(1);
        found   <= 1'b0;
        best_m  <= '0;
        best_n  <= N_W'(1);
        best_c  <= C_W'(1);
        win_ach <= '0;
        win_err <= '0;
      end
      if (cmd.next_n) n <= n + 1'b1;
      if (cmd.calc_vco) vco <= pfd * m;
      if (cmd.next_m) m <= m + 1'b1;
      // keep the first smallest error, then advance c
      if (cmd.next_c) begin
        c <= c + 1'b1;
        if (!found || err < win_err) begin
          found   <= 1'b1;
          win_err <= err;
          win_ach <= ach;
          best_m  <= m;
          best_n  <= n;
          best_c  <= c;
        end
      end
      // capture divider results
      if (div_done) begin
        unique case (sel)
          DIV_PFD: pfd <= quo[PFD_W-1:0];
          DIV_MLO: m_lo <= q_m_lo;
          DIV_MHI: begin
            m <= m_lo;
            if (quo >= DVD_W'(MAX_DIV - 1)) m_hi <= M_W'(MAX_DIV);
            else m_hi <= quo[M_W-1:0] + 1'b1;
          end
          DIV_C0: begin
            c <= (q_c0 > C_W'(1)) ? (q_c0 - 1'b1) : C_W'(1);
            if (q_c0 >= C_W'(MAX_DIV - 1)) c_hi <= C_W'(MAX_DIV);
            else c_hi <= q_c0 + 1'b1;
          end
          DIV_ACH: ach <= quo[VQ_W-1:0];
          default: ;
        endcase
      end
    end
  end

  // status toward the controller
  always_comb begin
    st.tgt_zero = (target == '0);
    st.n_over   = (n > N_W'(MAX_PRE_DIV));
    st.pfd_skip = (pfd == '0) || (pfd < floor_q);
    st.m_over   = (m > m_hi);
    st.vco_out  = (vco < PROD_W'(vmin_q)) || (vco > PROD_W'(vmax_q));
    st.c_over   = (c > c_hi);
    st.div_busy = div_busy;
    st.div_done = div_done;
  end

  // result fields
  assign ach_round   = {1'b0, win_ach} + (VQ_W+1)'(1 << (FRAC_BITS - 1));
  assign mult_m      = best_m;
  assign pre_div_n   = best_n;
  assign post_div_c  = best_c;
  assign achieved_hz = found ? ach_round[FRAC_BITS +: ACH_HZ_W] : '0;

endmodule

// File: src/pds_ctrl.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// pds_ctrl
// Sequencer of the n, m, c candidate scan over the shared divider.
// ---------------------------------------------------------------------------
module pds_ctrl (
  input  logic               clk,
  input  logic               rst,
  input  logic               start,
  input  pds_pkg::pds_stat_t st,
  output pds_pkg::pds_cmd_t  cmd,
  output logic               busy,
  output logic               done
);
  import pds_pkg::*;

  typedef enum logic [3:0] {
    S_IDLE,
    S_CHK_T,
    S_PFD_GO,
    S_PFD_W,
    S_PFD_CHK,
    S_MLO_W,
    S_MHI_GO,
    S_MHI_W,
    S_M_CHK,
    S_VCO_CHK,
    S_C0_W,
    S_C_CHK,
    S_ACH_W,
    S_UPD,
    S_DONE
  } state_t;

  state_t state;
  state_t state_next;
  logic   div_wait;

  // command decode and next state
  always_comb begin
    cmd        = '0;
    state_next = state;
    unique case (state)
      S_IDLE: if (start) begin
        cmd.load   = 1'b1;
        state_next = S_CHK_T;
      end
      S_CHK_T: state_next = st.tgt_zero ? S_DONE : S_PFD_GO;
      S_PFD_GO: begin
        if (st.n_over) begin
          state_next = S_DONE;
        end else begin
          cmd.div_go  = 1'b1;
          cmd.div_sel = DIV_PFD;
          state_next  = S_PFD_W;
        end
      end
      S_PFD_W: if (st.div_done) state_next = S_PFD_CHK;
      S_PFD_CHK: begin
        if (st.pfd_skip) begin
          cmd.next_n = 1'b1;
          state_next = S_PFD_GO;
        end else begin
          cmd.div_go  = 1'b1;
          cmd.div_sel = DIV_MLO;
          state_next  = S_MLO_W;
        end
      end
      S_MLO_W: if (st.div_done) state_next = S_MHI_GO;
      S_MHI_GO: begin
        cmd.div_go  = 1'b1;
        cmd.div_sel = DIV_MHI;
        state_next  = S_MHI_W;
      end
      S_MHI_W: if (st.div_done) state_next = S_M_CHK;
      S_M_CHK: begin
        if (st.m_over) begin
          cmd.next_n = 1'b1;
          state_next = S_PFD_GO;
        end else begin
          cmd.calc_vco = 1'b1;
          state_next   = S_VCO_CHK;
        end
      end
      S_VCO_CHK: begin
        if (st.vco_out) begin
          cmd.next_m = 1'b1;
          state_next = S_M_CHK;
        end else begin
          cmd.div_go  = 1'b1;
          cmd.div_sel = DIV_C0;
          state_next  = S_C0_W;
        end
      end
      S_C0_W: if (st.div_done) state_next = S_C_CHK;
      S_C_CHK: begin
        if (st.c_over) begin
          cmd.next_m = 1'b1;
          state_next = S_M_CHK;
        end else begin
          cmd.div_go  = 1'b1;
          cmd.div_sel = DIV_ACH;
          state_next  = S_ACH_W;
        end
      end
      S_ACH_W: if (st.div_done) state_next = S_UPD;
      S_UPD: begin
        cmd.next_c = 1'b1;
        state_next = S_C_CHK;
      end
      S_DONE: state_next = S_IDLE;
      default: state_next = S_IDLE;
    endcase
  end

  // hold state
  always_ff @(posedge clk) begin
    if (rst) state <= S_IDLE;
    else state <= state_next;
  end

  assign busy = (state != S_IDLE);
  assign done = (state == S_DONE);

  // states that wait on a divider quotient
  assign div_wait = (state == S_PFD_W) || (state == S_MLO_W) || (state == S_MHI_W) ||
                    (state == S_C0_W) || (state == S_ACH_W);

  `include "pll_divider_search_core_assert.svh"

  `PDS_ASSERT_NEXT(a_done_idle, done, !busy, "result strobe not followed by idle")
  `PDS_ASSERT_SAME(a_go_free, cmd.div_go, !st.div_busy, "divider launched while running")
  `PDS_ASSERT_NEXT(a_start_busy, start && !busy, busy, "request accepted but no search")
  `PDS_ASSERT_SAME(a_done_wait, st.div_done, div_wait, "quotient outside a wait state")

endmodule

// File: src/pll_divider_search_core.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// pll_divider_search_core
// Searches PLL pre-divider, multiplier and post-divider for a pixel clock.
// ---------------------------------------------------------------------------
//  channel   handshake         payload
//  request   start / busy      target_freq
//  result    done (strobe)     mult_m, pre_div_n, post_div_c, achieved_hz, found
//  config    cfg_we            cfg_index, cfg_data
//
// Each pre-divider costs one divide, two more when its phase-detector frequency
// passes the floor, and each VCO in the window one divide plus one per
// post-divider tried (up to three). busy is high from acceptance through the
// one-cycle done strobe; synchronous reset restores the register defaults and
// idles. The receiver cannot stall.
module pll_divider_search_core (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         start,
  output logic                         busy,
  input  logic [pds_pkg::TGT_W-1:0]    target_freq,
  output logic                         done,
  output logic [pds_pkg::M_W-1:0]      mult_m,
  output logic [pds_pkg::N_W-1:0]      pre_div_n,
  output logic [pds_pkg::C_W-1:0]      post_div_c,
  output logic [pds_pkg::ACH_HZ_W-1:0] achieved_hz,
  output logic                         found,
  input  logic                         cfg_we,
  input  logic [pds_pkg::IDX_W-1:0]    cfg_index,
  input  logic [pds_pkg::CFG_W-1:0]    cfg_data
);
  import pds_pkg::*;

  pds_cmd_t  cmd;
  pds_stat_t st;

  pds_ctrl u_ctrl (
    .clk   (clk),
    .rst   (rst),
    .start (start),
    .st    (st),
    .cmd   (cmd),
    .busy  (busy),
    .done  (done)
  );

  pds_datapath u_dp (
    .clk         (clk),
    .rst         (rst),
    .cfg_we      (cfg_we),
    .cfg_index   (cfg_index),
    .cfg_data    (cfg_data),
    .target_freq (target_freq),
    .cmd         (cmd),
    .st          (st),
    .mult_m      (mult_m),
    .pre_div_n   (pre_div_n),
    .post_div_c  (post_div_c),
    .achieved_hz (achieved_hz),
    .found       (found)
  );

endmodule

// File: tb/testbench.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// testbench
// Self-checking bench for pll_divider_search_core: a directed table of
// configuration writes and requests, then random targets under three register
// settings, each result checked against an in-bench divider search or a typed expectation.
// ---------------------------------------------------------------------------
module testbench;
  import pds_pkg::*;

  localparam int  LIMIT_CYCLES = 8000000;
  localparam int  DRAIN_CYCLES = 60;
  localparam logic [TGT_W-1:0] TGT_MAX = {TGT_W{1'b1}};

  typedef struct packed {
    logic [M_W-1:0]      m;
    logic [N_W-1:0]      n;
    logic [C_W-1:0]      c;
    logic [ACH_HZ_W-1:0] ach;
    logic                fnd;
  } pll_setting_t;

  typedef struct {
    bit               is_cfg;
    logic [IDX_W-1:0] idx;
    logic [CFG_W-1:0] data;
    logic [TGT_W-1:0] tgt;
    bit               typed;
    pll_setting_t     exp;
  } step_row_t;

  localparam pll_setting_t NOT_FOUND = '{m: '0, n: 1, c: 1, ach: '0, fnd: 1'b0};

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic start = 1'b0;
  logic busy;
  logic [TGT_W-1:0] target_freq = '0;
  logic done;
  logic [M_W-1:0] mult_m;
  logic [N_W-1:0] pre_div_n;
  logic [C_W-1:0] post_div_c;
  logic [ACH_HZ_W-1:0] achieved_hz;
  logic found;
  logic cfg_we = 1'b0;
  logic [IDX_W-1:0] cfg_index = '0;
  logic [CFG_W-1:0] cfg_data = '0;

  // shadow registers
  logic [63:0] ref_hz, vmin_hz, vmax_hz, pmin_hz;

  pll_setting_t settings_q[$];
  bit           next_typed;
  pll_setting_t next_typed_exp;
  int           accepted;
  int           errors;
  int           cycles;
  int           idle_pct;

  pll_divider_search_core uut (.*);

  always #2 clk = ~clk;

  // cycle limit
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > LIMIT_CYCLES) begin
      $display("TEST FAILED");
      $finish;
    end
  end

  // best divider triple for one target under the shadow registers
  function automatic pll_setting_t search_dividers(logic [TGT_W-1:0] tgt);
    pll_setting_t best;
    logic [63:0] tq, vminq, vmaxq, floorq, pfd, mlo, mhi, vco, c0, clo, chi, ach, err;
    logic [63:0] win_err, win_ach;
    bit hit;
    best = NOT_FOUND;
    win_err = '0;
    win_ach = '0;
    hit = 1'b0;
    if (tgt != 0) begin
      tq = 64'(tgt) << FRAC_BITS;
      vminq = vmin_hz << FRAC_BITS;
      vmaxq = vmax_hz << FRAC_BITS;
      floorq = pmin_hz << FRAC_BITS;
      for (int n = 1; n <= MAX_PRE_DIV; n++) begin
        pfd = (ref_hz << FRAC_BITS) / n;
        if (pfd == 0 || pfd < floorq) continue;
        mlo = vminq / pfd;
        if (mlo < 1) mlo = 1;
        mhi = vmaxq / pfd + 1;
        if (mhi > MAX_DIV) mhi = MAX_DIV;
        for (logic [63:0] m = mlo; m <= mhi; m++) begin
          vco = pfd * m;
          if (vco < vminq || vco > vmaxq) continue;
          c0 = (vco + (64'(tgt) << (FRAC_BITS - 1))) / tq;
          clo = (c0 > 1) ? c0 - 1 : 1;
          chi = c0 + 1;
          if (chi > MAX_DIV) chi = MAX_DIV;
          for (logic [63:0] c = clo; c <= chi; c++) begin
            ach = vco / c;
            err = (ach >= tq) ? ach - tq : tq - ach;
            if (!hit || err < win_err) begin
              hit = 1'b1;
              win_err = err;
              win_ach = ach;
              best.m = m[M_W-1:0];
              best.n = N_W'(n);
              best.c = c[C_W-1:0];
            end
          end
        end
      end
    end
    if (hit) begin
      best.ach = ACH_HZ_W'((win_ach + (64'd1 << (FRAC_BITS - 1))) >> FRAC_BITS);
      best.fnd = 1'b1;
    end
    return best;
  endfunction

  task automatic report_mismatch(string what, logic [63:0] got, logic [63:0] want);
    $display("mismatch %s: got %0d expected %0d at cycle %0d", what, got, want, cycles);
    errors++;
  endtask

  // take requests and check results
  always @(posedge clk) begin
    pll_setting_t want;
    if (!rst) begin
      if (start && !busy) begin
        settings_q.push_back(next_typed ? next_typed_exp : search_dividers(target_freq));
        accepted++;
      end
      if (done) begin
        if (settings_q.size() == 0) begin
          report_mismatch("unexpected result", 1, 0);
        end else begin
          want = settings_q.pop_front();
          if (mult_m !== want.m) report_mismatch("mult_m", mult_m, want.m);
          if (pre_div_n !== want.n) report_mismatch("pre_div_n", pre_div_n, want.n);
          if (post_div_c !== want.c) report_mismatch("post_div_c", post_div_c, want.c);
          if (achieved_hz !== want.ach) report_mismatch("achieved_hz", achieved_hz, want.ach);
          if (found !== want.fnd) report_mismatch("found", found, want.fnd);
        end
      end
    end
  end

  task automatic write_reg(logic [IDX_W-1:0] idx, logic [CFG_W-1:0] data);
    @(negedge clk);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= data;
    case (idx)
      REG_REF_CLOCK: ref_hz = 64'(data[REF_W-1:0]);
      REG_VCO_MIN:   vmin_hz = 64'(data);
      REG_VCO_MAX:   vmax_hz = 64'(data);
      REG_PFD_MIN:   pmin_hz = 64'(data[PFD_HZ_W-1:0]);
      default: ;
    endcase
    @(negedge clk);
    cfg_we <= 1'b0;
  endtask

  // hold until every result is back and the sequencer is quiet
  task automatic wait_idle();
    while (settings_q.size() != 0 || busy) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  // issue one request, sometimes after a random gap
  task automatic send_request(logic [TGT_W-1:0] tgt, bit typed, pll_setting_t exp);
    int seen;
    if ($urandom_range(99) < idle_pct) begin
      @(negedge clk);
      start <= 1'b0;
      repeat ($urandom_range(6)) @(negedge clk);
    end
    @(negedge clk);
    start <= 1'b1;
    target_freq <= tgt;
    next_typed = typed;
    next_typed_exp = exp;
    seen = accepted;
    while (accepted == seen) @(posedge clk);
  endtask

  task automatic stop_requests();
    @(negedge clk);
    start <= 1'b0;
  endtask

  function automatic logic [TGT_W-1:0] random_target();
    if ($urandom_range(3) == 0) return TGT_W'($urandom);
    return TGT_W'($urandom_range(400000000, 1000000));
  endfunction

  step_row_t steps[] = '{
    '{0, REG_REF_CLOCK, 0, 0, 1, NOT_FOUND},
    '{0, REG_REF_CLOCK, 0, 25175000, 0, NOT_FOUND},
    '{1, REG_REF_CLOCK, 200000000, 0, 0, NOT_FOUND},
    '{1, REG_PFD_MIN, 100000000, 0, 0, NOT_FOUND},
    '{0, REG_REF_CLOCK, 0, 108000000, 0, NOT_FOUND},
    '{0, REG_REF_CLOCK, 0, 1300000000, 0, NOT_FOUND},
    '{0, REG_REF_CLOCK, 0, TGT_MAX, 0, NOT_FOUND},
    '{0, REG_REF_CLOCK, 0, 1, 0, NOT_FOUND},
    '{1, REG_REF_CLOCK, 1000000, 0, 0, NOT_FOUND},
    '{1, REG_PFD_MIN, 1, 0, 0, NOT_FOUND},
    '{1, REG_VCO_MIN, 400000000, 0, 0, NOT_FOUND},
    '{1, REG_VCO_MAX, 401000000, 0, 0, NOT_FOUND},
    '{0, REG_REF_CLOCK, 0, 50000000, 0, NOT_FOUND},
    '{0, REG_REF_CLOCK, 0, 1, 0, NOT_FOUND},
    '{1, REG_REF_CLOCK, 200000000, 0, 0, NOT_FOUND},
    '{1, REG_PFD_MIN, 200000000, 0, 0, NOT_FOUND},
    '{1, REG_VCO_MIN, 32'd4000000000, 0, 0, NOT_FOUND},
    '{1, REG_VCO_MAX, 1, 0, 0, NOT_FOUND},
    '{0, REG_REF_CLOCK, 0, 74250000, 1, NOT_FOUND},
    '{1, REG_VCO_MIN, 1, 0, 0, NOT_FOUND},
    '{1, REG_VCO_MAX, 32'd4000000000, 0, 0, NOT_FOUND},
    '{0, REG_REF_CLOCK, 0, TGT_MAX, 0, NOT_FOUND},
    '{0, REG_REF_CLOCK, 0, 1, 0, NOT_FOUND},
    '{0, REG_REF_CLOCK, 0, 148500000, 0, NOT_FOUND}
  };

  initial begin
    logic [31:0] ref_pick, vlo;
    ref_hz = 50000000;
    vmin_hz = 600000000;
    vmax_hz = 1300000000;
    pmin_hz = 5000000;
    idle_pct = 24;
    next_typed = 1'b0;
    next_typed_exp = NOT_FOUND;
    repeat (11) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // directed table
    foreach (steps[i]) begin
      if (steps[i].is_cfg) begin
        stop_requests();
        wait_idle();
        write_reg(steps[i].idx, steps[i].data);
      end else begin
        send_request(steps[i].tgt, steps[i].typed, steps[i].exp);
      end
    end

    // random targets under three settings, sender gaps changing per phase
    for (int ph = 0; ph < 3; ph++) begin
      stop_requests();
      wait_idle();
      idle_pct = (ph == 0) ? 24 : (ph == 1) ? 78 : 0;
      if (ph == 0) begin
        write_reg(REG_REF_CLOCK, 200000000);
        write_reg(REG_PFD_MIN, 100000000);
        write_reg(REG_VCO_MIN, 600000000);
        write_reg(REG_VCO_MAX, 1300000000);
      end else begin
        ref_pick = $urandom_range(200000000, 150000000);
        vlo = $urandom_range(1000000000, 300000000);
        write_reg(REG_REF_CLOCK, ref_pick);
        write_reg(REG_PFD_MIN, ref_pick / 3);
        write_reg(REG_VCO_MIN, vlo);
        write_reg(REG_VCO_MAX, vlo + $urandom_range(1000000000, 1000000));
      end
      for (int k = 0; k < 34; k++) send_request(random_target(), 1'b0, NOT_FOUND);
    end

    stop_requests();
    wait_idle();
    if (errors == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule
